// ----- rtl/core/bsmc_pkg.sv -----
// Package for the burn shutdown mode controller: field widths, item kinds,
// event codes and reset values of the configuration registers.
// No dependencies.
package bsmc_pkg;

  localparam int unsigned RunCountBitsDef = 8;
  localparam int unsigned TimerBitsDef    = 20;

  localparam int unsigned FuncW     = 2;
  localparam int unsigned EventW    = 3;
  localparam int unsigned PressureW = 16;
  localparam int unsigned ApogeeW   = 24;
  localparam int unsigned GroundW   = 21;
  localparam int unsigned InDataW   = 64;

  localparam int unsigned ModeW     = 3;
  localparam int unsigned RunOutW   = 8;
  localparam int unsigned OutDataW  = 16;

  localparam int unsigned SamplesW  = 8;
  localparam int unsigned TicksW    = 20;
  localparam int unsigned TargetW   = 20;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 20;

  typedef enum logic [FuncW-1:0] {
    FUNC_EVENT  = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [EventW-1:0] {
    EV_FORCE_START = 3'd0,
    EV_FORCE_STOP  = 3'd1,
    EV_ARMED       = 3'd2,
    EV_DISARMED    = 3'd3,
    EV_LIFTOFF     = 3'd4,
    EV_MOTOR_OFF   = 3'd5,
    EV_APOGEE      = 3'd6,
    EV_LANDING     = 3'd7
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRESSURE_THR = 2'd0,
    CFG_SHUTDOWN_SMP = 2'd1,
    CFG_MIN_BURN     = 2'd2,
    CFG_APOGEE_TGT   = 2'd3
  } cfg_idx_e;

  localparam logic [PressureW-1:0] PressureThrRst = 16'd100;
  localparam logic [SamplesW-1:0]  ShutdownSmpRst = 8'd5;
  localparam logic [TicksW-1:0]    MinBurnRst     = 20'd3500;
  localparam logic [TargetW-1:0]   ApogeeTgtRst   = 20'd30000;

endpackage

// ----- rtl/core/burn_shutdown_mode_controller_core.sv -----
// Burn shutdown mode controller: mode sequencing, shadow timer and
// over-target sample run counting in one registered pass per item.
// Depends on bsmc_pkg.
//
// channel  | direction | handshake                     | payload
// s_axis   | in        | s_axis_tvalid / s_axis_tready | tuser: func; tdata: event, pressure,
//          |           |                               |   predicted apogee, ground altitude
// m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata: mode, shutdown, taken, run
// cfg      | in        | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled; each input transaction
// passes the input register, then the decision logic into the result register.
// A stalled output holds its result while one more item waits in the input
// register; input ready drops only when both are full.
// Reset: mode ready, run count and timer zero, registers at their defaults.
module burn_shutdown_mode_controller_core
  import bsmc_pkg::*;
#(
  parameter int unsigned RUN_COUNT_BITS = RunCountBitsDef,
  parameter int unsigned TIMER_BITS     = TimerBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: event_code[2:0], chamber_pressure[18:3], predicted_apogee[42:19],
  //        ground_altitude[63:43]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: func[1:0]
  input  logic [FuncW-1:0]    s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: mode[2:0], shutdown_detected[3], sample_taken[4],
  //        over_target_run[12:5], zeros[15:13]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [ModeW-1:0] {
    MODE_READY     = 3'd0,
    MODE_ARMED     = 3'd1,
    MODE_SHADOW    = 3'd2,
    MODE_ACTIVE    = 3'd3,
    MODE_UNPOWERED = 3'd4,
    MODE_END       = 3'd5
  } mode_e;

  localparam int unsigned RunCmpW   = (RUN_COUNT_BITS > SamplesW) ? RUN_COUNT_BITS : SamplesW;
  localparam int unsigned TimerCmpW = (TIMER_BITS > TicksW) ? TIMER_BITS : TicksW;
  localparam logic [RUN_COUNT_BITS-1:0] RunMax   = '1;
  localparam logic [TIMER_BITS-1:0]     TimerMax = '1;

  // configuration registers
  logic [PressureW-1:0] pressure_thr_q;
  logic [SamplesW-1:0]  shutdown_smp_q;
  logic [TicksW-1:0]    min_burn_q;
  logic [TargetW-1:0]   apogee_tgt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressure_thr_q <= PressureThrRst;
      shutdown_smp_q <= ShutdownSmpRst;
      min_burn_q     <= MinBurnRst;
      apogee_tgt_q   <= ApogeeTgtRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PRESSURE_THR: pressure_thr_q <= cfg_data_i[PressureW-1:0];
        CFG_SHUTDOWN_SMP: shutdown_smp_q <= cfg_data_i[SamplesW-1:0];
        CFG_MIN_BURN:     min_burn_q     <= cfg_data_i[TicksW-1:0];
        CFG_APOGEE_TGT:   apogee_tgt_q   <= cfg_data_i[TargetW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                 in_valid_q;
  logic [FuncW-1:0]     func_q;
  logic [EventW-1:0]    event_q;
  logic [PressureW-1:0] pressure_q;
  logic [ApogeeW-1:0]   apogee_q;
  logic [GroundW-1:0]   ground_q;
  logic                 advance;

  assign advance       = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q     <= s_axis_tuser;
      event_q    <= s_axis_tdata[2:0];
      pressure_q <= s_axis_tdata[18:3];
      apogee_q   <= s_axis_tdata[42:19];
      ground_q   <= s_axis_tdata[63:43];
    end
  end

  // controller state
  mode_e                     mode_q, mode_d;
  logic [RUN_COUNT_BITS-1:0] run_q, run_d;
  logic [TIMER_BITS-1:0]     timer_q, timer_d;

  logic                  flag_d, taken_d;
  mode_e                 ev_mode;
  logic [TIMER_BITS-1:0] timer_inc;
  logic                  timer_done;
  logic                  gated_mode;
  logic                  over_target;
  logic signed [ApogeeW:0] limit;

  always_comb begin
    ev_mode = mode_q;
    case (mode_q)
      MODE_READY: begin
        if (event_q inside {EV_FORCE_START, EV_ARMED}) ev_mode = MODE_ARMED;
      end
      MODE_ARMED: begin
        if (event_q inside {EV_FORCE_STOP, EV_DISARMED}) ev_mode = MODE_READY;
        else if (event_q == EV_LIFTOFF) ev_mode = MODE_SHADOW;
      end
      MODE_SHADOW, MODE_ACTIVE: begin
        if (event_q == EV_FORCE_STOP) ev_mode = MODE_READY;
        else if (event_q == EV_MOTOR_OFF) ev_mode = MODE_UNPOWERED;
        else if (event_q == EV_LANDING) ev_mode = MODE_END;
      end
      MODE_UNPOWERED: begin
        if (event_q == EV_FORCE_STOP) ev_mode = MODE_READY;
        else if (event_q inside {EV_APOGEE, EV_LANDING}) ev_mode = MODE_END;
      end
      default: ;
    endcase
  end

  assign timer_inc  = (timer_q == TimerMax) ? timer_q : timer_q + 1'b1;
  assign timer_done = TimerCmpW'(timer_inc) >= TimerCmpW'(min_burn_q);
  assign gated_mode = (mode_q == MODE_SHADOW) || (mode_q == MODE_ACTIVE) ||
                      (mode_q == MODE_UNPOWERED);
  // target above ground plus ground altitude, both sides widened to 25 bits
  assign limit       = $signed({{(ApogeeW + 1 - GroundW){ground_q[GroundW-1]}}, ground_q}) +
                       $signed({{(ApogeeW + 1 - TargetW){1'b0}}, apogee_tgt_q});
  assign over_target = $signed({apogee_q[ApogeeW-1], apogee_q}) > limit;

  always_comb begin
    mode_d  = mode_q;
    run_d   = run_q;
    timer_d = timer_q;
    flag_d  = 1'b0;
    taken_d = 1'b0;
    case (func_e'(func_q))
      FUNC_EVENT: begin
        mode_d = ev_mode;
        // clear the timer on any mode change, including entering or leaving shadow
        if (ev_mode != mode_q) timer_d = '0;
      end
      FUNC_TICK: begin
        if (mode_q == MODE_SHADOW) begin
          if (timer_done) begin
            mode_d  = MODE_ACTIVE;
            timer_d = '0;
          end else begin
            timer_d = timer_inc;
          end
        end
      end
      FUNC_SAMPLE: begin
        if (gated_mode && (pressure_q > pressure_thr_q)) begin
          taken_d = 1'b1;
          if (over_target) run_d = (run_q == RunMax) ? run_q : run_q + 1'b1;
          else run_d = '0;
          flag_d = (mode_q == MODE_ACTIVE) &&
                   (RunCmpW'(run_d) >= RunCmpW'(shutdown_smp_q));
        end
      end
      default: ;
    endcase
  end

  logic [RunOutW-1:0] run_shown;

  generate
    if (RUN_COUNT_BITS > RunOutW) begin : g_run_sat
      assign run_shown = (run_d > RUN_COUNT_BITS'({RunOutW{1'b1}})) ? '1 : run_d[RunOutW-1:0];
    end else begin : g_run_ext
      assign run_shown = RunOutW'(run_d);
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_READY;
      run_q   <= '0;
      timer_q <= '0;
    end else if (advance) begin
      mode_q  <= mode_d;
      run_q   <= run_d;
      timer_q <= timer_d;
    end
  end

  // result register
  logic [ModeW-1:0]   res_mode_q;
  logic               res_flag_q;
  logic               res_taken_q;
  logic [RunOutW-1:0] res_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_mode_q  <= mode_d;
      res_flag_q  <= flag_d;
      res_taken_q <= taken_d;
      res_run_q   <= run_shown;
    end
  end

  assign m_axis_tdata = {3'b000, res_run_q, res_taken_q, res_flag_q, res_mode_q};

  // the timer only runs in shadow mode
  a_timer_shadow_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (timer_q != '0) |-> (mode_q == MODE_SHADOW))
    else $error("shadow timer nonzero outside shadow mode");

  a_flag_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_flag_q) |-> (res_taken_q && (res_mode_q == MODE_ACTIVE)))
    else $error("shutdown flag without a used sample in active mode");

  a_run_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (func_q != FUNC_SAMPLE)) |=> (run_q == $past(run_q)))
    else $error("run count changed on a non-sample item");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stalled with an empty input register");

endmodule
